FILE: sv/pss_pkg.sv
// Shared types and constants for the power switch scheduler.
package pss_pkg;

  localparam int unsigned SwitchChannelsDefault = 16;
  localparam int unsigned DelayBitsDefault      = 32;
  localparam int unsigned ActionW               = 4;
  localparam int unsigned ChannelW              = 5;
  localparam int unsigned DelayInW              = 32;
  localparam int unsigned MaskW                 = 16;

  localparam logic [ActionW-1:0] ACT_OFF         = 4'd0;
  localparam logic [ActionW-1:0] ACT_ON          = 4'd1;
  localparam logic [ActionW-1:0] ACT_TOGGLE      = 4'd2;
  localparam logic [ActionW-1:0] ACT_SAVE        = 4'd3;
  localparam logic [ActionW-1:0] ACT_SCHED_ON    = 4'd4;
  localparam logic [ActionW-1:0] ACT_SCHED_OFF   = 4'd5;
  localparam logic [ActionW-1:0] ACT_SCHED_RESET = 4'd6;
  localparam logic [ActionW-1:0] ACT_HALT        = 4'd7;
  localparam logic [ActionW-1:0] ACT_TICK        = 4'd8;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_OFF,
    OP_ON,
    OP_TOGGLE,
    OP_SAVE,
    OP_ARM_ON,
    OP_ARM_OFF,
    OP_DISARM,
    OP_BL_ON,
    OP_BL_OFF,
    OP_HALT,
    OP_TICK
  } op_kind_t;

  typedef struct packed {
    logic [MaskW-1:0] switch_mask;
    logic             backlight_on;
    logic             backlight_write;
    logic             save_request;
    logic             halt_request;
    logic             halted;
  } res_t;

endpackage

FILE: sv/pss_front.sv
// Front end: accepts commands, classifies them and queues them for the executor.
module pss_front #(
  parameter int unsigned SWITCH_CHANNELS = pss_pkg::SwitchChannelsDefault,
  parameter int unsigned DELAY_BITS      = pss_pkg::DelayBitsDefault,
  parameter int unsigned CH_W            = (SWITCH_CHANNELS > 1) ? $clog2(SWITCH_CHANNELS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [pss_pkg::ActionW-1:0]   in_action,
  input  logic [pss_pkg::ChannelW-1:0]  in_channel,
  input  logic [pss_pkg::DelayInW-1:0]  in_delay,
  input  logic [SWITCH_CHANNELS:0]      present_mask,
  output logic                          q_valid,
  input  logic                          q_take,
  output pss_pkg::op_kind_t             q_kind,
  output logic [CH_W-1:0]               q_ch,
  output logic [DELAY_BITS-1:0]         q_delay
);
  import pss_pkg::*;

  op_kind_t                   kind_q_r  [2];
  logic [CH_W-1:0]            ch_q_r    [2];
  logic [DELAY_BITS-1:0]      delay_q_r [2];
  logic                       wr_ptr_r, wr_ptr_nxt;
  logic                       rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                 count_r, count_nxt;

  op_kind_t                   kind;
  logic                       present;
  logic                       accept;
  logic [DELAY_BITS+DelayInW-1:0] delay_ext;

  assign delay_ext = (DELAY_BITS + DelayInW)'(in_delay);

  always_comb begin
    present = 1'b0;
    if (32'(in_channel) == SWITCH_CHANNELS) begin
      present = present_mask[SWITCH_CHANNELS];
    end else if (32'(in_channel) < SWITCH_CHANNELS) begin
      present = present_mask[{1'b0, in_channel[CH_W-1:0]}];
    end
  end

  always_comb begin
    kind = OP_NONE;
    if (in_action == ACT_TICK) begin
      kind = OP_TICK;
    end else if (in_action == ACT_HALT) begin
      kind = OP_HALT;
    end else if (in_action < ACT_HALT && present) begin
      if (32'(in_channel) == SWITCH_CHANNELS) begin
        kind = (in_action == ACT_ON) ? OP_BL_ON : OP_BL_OFF;
      end else begin
        case (in_action)
          ACT_OFF:         kind = OP_OFF;
          ACT_ON:          kind = OP_ON;
          ACT_TOGGLE:      kind = OP_TOGGLE;
          ACT_SAVE:        kind = OP_SAVE;
          ACT_SCHED_ON:    kind = OP_ARM_ON;
          ACT_SCHED_OFF:   kind = OP_ARM_OFF;
          ACT_SCHED_RESET: kind = OP_DISARM;
          default:         kind = OP_NONE;
        endcase
      end
    end
  end

  assign full    = (count_r == 2'd2);
  assign accept  = push && !full;
  assign q_valid = (count_r != 2'd0);
  assign q_kind  = kind_q_r[rd_ptr_r];
  assign q_ch    = ch_q_r[rd_ptr_r];
  assign q_delay = delay_q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ accept;
    rd_ptr_nxt = rd_ptr_r ^ (q_take && q_valid);
    count_nxt  = count_r + 2'(accept) - 2'(q_take && q_valid);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q_r[wr_ptr_r]  <= kind;
      ch_q_r[wr_ptr_r]    <= in_channel[CH_W-1:0];
      delay_q_r[wr_ptr_r] <= delay_ext[DELAY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: sv/pss_back.sv
// Executor: applies commands and scans the countdown memories on each tick.
module pss_back #(
  parameter int unsigned SWITCH_CHANNELS = pss_pkg::SwitchChannelsDefault,
  parameter int unsigned DELAY_BITS      = pss_pkg::DelayBitsDefault,
  parameter int unsigned CH_W            = (SWITCH_CHANNELS > 1) ? $clog2(SWITCH_CHANNELS) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [SWITCH_CHANNELS:0] present_mask,
  input  logic                     q_valid,
  output logic                     q_take,
  input  pss_pkg::op_kind_t        q_kind,
  input  logic [CH_W-1:0]          q_ch,
  input  logic [DELAY_BITS-1:0]    q_delay,
  input  logic                     res_full,
  output logic                     res_push,
  output pss_pkg::res_t            res_data
);
  import pss_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CH_W:0]              idx_r, idx_nxt;
  logic                       stg_vld_r, stg_vld_nxt;
  logic [CH_W-1:0]            stg_idx_r, stg_idx_nxt;
  logic [SWITCH_CHANNELS-1:0] sw_r, sw_nxt;
  logic                       bl_r, bl_nxt;
  logic                       halt_r, halt_nxt;
  logic [SWITCH_CHANNELS-1:0] on_armed_r, on_armed_nxt;
  logic [SWITCH_CHANNELS-1:0] off_armed_r, off_armed_nxt;

  logic [DELAY_BITS-1:0]      on_mem  [SWITCH_CHANNELS];
  logic [DELAY_BITS-1:0]      off_mem [SWITCH_CHANNELS];
  logic [DELAY_BITS-1:0]      on_rd_r, off_rd_r;
  logic [CH_W-1:0]            rd_addr;
  logic                       on_we, off_we;
  logic [CH_W-1:0]            wr_addr;
  logic [DELAY_BITS-1:0]      on_wd, off_wd;

  logic                       blw, save, hreq;
  logic [SWITCH_CHANNELS+MaskW-1:0] sw_ext;

  assign rd_addr = idx_r[CH_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    stg_vld_nxt   = stg_vld_r;
    stg_idx_nxt   = stg_idx_r;
    sw_nxt        = sw_r;
    bl_nxt        = bl_r;
    halt_nxt      = halt_r;
    on_armed_nxt  = on_armed_r;
    off_armed_nxt = off_armed_r;
    q_take        = 1'b0;
    res_push      = 1'b0;
    blw           = 1'b0;
    save          = 1'b0;
    hreq          = 1'b0;
    on_we         = 1'b0;
    off_we        = 1'b0;
    wr_addr       = q_ch;
    on_wd         = q_delay;
    off_wd        = q_delay;
    case (state_r)
      S_IDLE: begin
        if (q_valid && !res_full) begin
          q_take = 1'b1;
          if (q_kind == OP_TICK) begin
            state_nxt   = S_SCAN;
            idx_nxt     = '0;
            stg_vld_nxt = 1'b0;
          end else begin
            res_push = 1'b1;
            if (!halt_r) begin
              case (q_kind)
                OP_OFF:     sw_nxt[q_ch] = 1'b0;
                OP_ON:      sw_nxt[q_ch] = 1'b1;
                OP_TOGGLE:  sw_nxt[q_ch] = !sw_r[q_ch];
                OP_SAVE:    save = 1'b1;
                OP_ARM_ON: begin
                  on_armed_nxt[q_ch] = 1'b1;
                  on_we              = 1'b1;
                end
                OP_ARM_OFF: begin
                  off_armed_nxt[q_ch] = 1'b1;
                  off_we              = 1'b1;
                end
                OP_DISARM: begin
                  on_armed_nxt[q_ch]  = 1'b0;
                  off_armed_nxt[q_ch] = 1'b0;
                end
                OP_BL_ON: begin
                  bl_nxt = 1'b1;
                  blw    = 1'b1;
                end
                OP_BL_OFF: begin
                  bl_nxt = 1'b0;
                  blw    = 1'b1;
                end
                OP_HALT: begin
                  halt_nxt = 1'b1;
                  hreq     = 1'b1;
                end
                default: ;
              endcase
            end
          end
        end
      end
      S_SCAN: begin
        if (idx_r < (CH_W + 1)'(SWITCH_CHANNELS)) begin
          stg_vld_nxt = 1'b1;
          stg_idx_nxt = idx_r[CH_W-1:0];
          idx_nxt     = idx_r + 1'b1;
        end else begin
          stg_vld_nxt = 1'b0;
        end
        if (stg_vld_r) begin
          wr_addr = stg_idx_r;
          on_wd   = on_rd_r - DELAY_BITS'(1);
          off_wd  = off_rd_r - DELAY_BITS'(1);
          if (on_armed_r[stg_idx_r]) begin
            if (on_rd_r <= DELAY_BITS'(1)) begin
              on_armed_nxt[stg_idx_r] = 1'b0;
              if (!halt_r && present_mask[{1'b0, stg_idx_r}]) begin
                sw_nxt[stg_idx_r] = 1'b1;
              end
            end else begin
              on_we = 1'b1;
            end
          end
          if (off_armed_r[stg_idx_r]) begin
            if (off_rd_r <= DELAY_BITS'(1)) begin
              off_armed_nxt[stg_idx_r] = 1'b0;
              if (!halt_r && present_mask[{1'b0, stg_idx_r}]) begin
                sw_nxt[stg_idx_r] = 1'b0;
              end
            end else begin
              off_we = 1'b1;
            end
          end
          if (stg_idx_r == CH_W'(SWITCH_CHANNELS - 1)) begin
            res_push    = 1'b1;
            state_nxt   = S_IDLE;
            stg_vld_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign sw_ext = (SWITCH_CHANNELS + MaskW)'(sw_nxt);

  always_comb begin
    res_data.switch_mask     = sw_ext[MaskW-1:0];
    res_data.backlight_on    = bl_nxt;
    res_data.backlight_write = blw;
    res_data.save_request    = save;
    res_data.halt_request    = hreq;
    res_data.halted          = halt_nxt;
  end

  always_ff @(posedge clk) begin
    if (on_we) begin
      on_mem[wr_addr] <= on_wd;
    end
    if (off_we) begin
      off_mem[wr_addr] <= off_wd;
    end
    on_rd_r  <= on_mem[rd_addr];
    off_rd_r <= off_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      stg_vld_r   <= 1'b0;
      stg_idx_r   <= '0;
      sw_r        <= '0;
      bl_r        <= 1'b0;
      halt_r      <= 1'b0;
      on_armed_r  <= '0;
      off_armed_r <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      stg_vld_r   <= stg_vld_nxt;
      stg_idx_r   <= stg_idx_nxt;
      sw_r        <= sw_nxt;
      bl_r        <= bl_nxt;
      halt_r      <= halt_nxt;
      on_armed_r  <= on_armed_nxt;
      off_armed_r <= off_armed_nxt;
    end
  end

endmodule

FILE: sv/pss_result_fifo.sv
// Two-entry result queue between the executor and the result port.
module pss_result_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_push,
  input  pss_pkg::res_t  res_data,
  output logic           res_full,
  output logic           empty,
  input  logic           pop,
  output pss_pkg::res_t  out_data
);
  import pss_pkg::*;

  res_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign res_full = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;
  assign out_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: sv/power_switch_scheduler.sv
// Power switch scheduler top level: 16 switch outputs, backlight and countdowns.
// Usage:
//   Commands enter through a queue port: drive in_action, in_channel, in_delay
//   and raise push; a transaction completes on a clock edge with push high and
//   full low. Two commands can wait ahead of the executor.
//   Every command yields exactly one result transaction: while empty is low the
//   oldest result is on the out_ ports, and pop high takes it. Results show the
//   switch and backlight state after the command plus its one-shot strobes.
//   With the executor idle, a result passes from its input transaction through
//   the command queue, the executor and the result queue. A switch, save,
//   schedule, halt or backlight command is applied as soon as the executor
//   takes it; a tick is taken, then the executor scans the countdown memories,
//   one channel per cycle through a single read port, each read registered.
//   Write the present mask via cfg_valid/cfg_ready/cfg_data only while no
//   command is outstanding (cfg_ready is always high); the block does not check.
//   If the receiver stalls, the two-entry result queue fills, the executor
//   waits, then the command queue fills and full rises; nothing is lost.
//   Synchronous reset clears the switch and backlight state and both queues,
//   disarms all countdowns, unlatches halt and sets every channel present.
module power_switch_scheduler #(
  parameter int unsigned SWITCH_CHANNELS = pss_pkg::SwitchChannelsDefault,
  parameter int unsigned DELAY_BITS      = pss_pkg::DelayBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [pss_pkg::ActionW-1:0]   in_action,
  input  logic [pss_pkg::ChannelW-1:0]  in_channel,
  input  logic [pss_pkg::DelayInW-1:0]  in_delay,
  output logic                          empty,
  input  logic                          pop,
  output logic [pss_pkg::MaskW-1:0]     out_switch_mask,
  output logic                          out_backlight_on,
  output logic                          out_backlight_write,
  output logic                          out_save_request,
  output logic                          out_halt_request,
  output logic                          out_halted,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [SWITCH_CHANNELS:0]      cfg_data
);
  import pss_pkg::*;

  localparam int unsigned CH_W = (SWITCH_CHANNELS > 1) ? $clog2(SWITCH_CHANNELS) : 1;

  logic [SWITCH_CHANNELS:0] present_r;
  logic                     q_valid, q_take;
  op_kind_t                 q_kind;
  logic [CH_W-1:0]          q_ch;
  logic [DELAY_BITS-1:0]    q_delay;
  logic                     res_full, res_push;
  res_t                     res_data, out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '1;
    end else if (cfg_valid && cfg_ready) begin
      present_r <= cfg_data;
    end
  end

  pss_front #(
    .SWITCH_CHANNELS (SWITCH_CHANNELS),
    .DELAY_BITS      (DELAY_BITS),
    .CH_W            (CH_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_action    (in_action),
    .in_channel   (in_channel),
    .in_delay     (in_delay),
    .present_mask (present_r),
    .q_valid      (q_valid),
    .q_take       (q_take),
    .q_kind       (q_kind),
    .q_ch         (q_ch),
    .q_delay      (q_delay)
  );

  pss_back #(
    .SWITCH_CHANNELS (SWITCH_CHANNELS),
    .DELAY_BITS      (DELAY_BITS),
    .CH_W            (CH_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .present_mask (present_r),
    .q_valid      (q_valid),
    .q_take       (q_take),
    .q_kind       (q_kind),
    .q_ch         (q_ch),
    .q_delay      (q_delay),
    .res_full     (res_full),
    .res_push     (res_push),
    .res_data     (res_data)
  );

  pss_result_fifo u_res (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_data (res_data),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  assign out_switch_mask     = out_data.switch_mask;
  assign out_backlight_on    = out_data.backlight_on;
  assign out_backlight_write = out_data.backlight_write;
  assign out_save_request    = out_data.save_request;
  assign out_halt_request    = out_data.halt_request;
  assign out_halted          = out_data.halted;

endmodule

FILE: tb/sv/power_switch_scheduler_test.sv
// Self-checking testbench for the power switch scheduler: directed table plus random commands.
module power_switch_scheduler_test;
  import pss_pkg::*;

  localparam int unsigned SwCh = SwitchChannelsDefault;
  localparam int unsigned SwIdxW = $clog2(SwCh);
  localparam logic [ChannelW-1:0] BacklightCh = ChannelW'(SwCh);
  localparam logic [ActionW-1:0] ACT_UNUSED_LO = 4'd9;
  localparam logic [ActionW-1:0] ACT_UNUSED_HI = 4'd15;
  localparam res_t NoStatus = '0;
  localparam int PhaseQuota = 150;

  typedef struct {
    logic [ActionW-1:0]  act;
    logic [ChannelW-1:0] ch;
    logic [DelayInW-1:0] dly;
    bit                  fixed;
    res_t                want;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                push;
  logic                full;
  logic [ActionW-1:0]  in_action;
  logic [ChannelW-1:0] in_channel;
  logic [DelayInW-1:0] in_delay;
  logic                empty;
  logic                pop;
  logic [MaskW-1:0]    out_switch_mask;
  logic                out_backlight_on;
  logic                out_backlight_write;
  logic                out_save_request;
  logic                out_halt_request;
  logic                out_halted;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [SwCh:0]       cfg_data;

  // scheduler state as predicted
  logic [SwCh:0]       model_present;
  logic [SwCh-1:0]     model_switches;
  logic [SwCh-1:0]     model_on_armed;
  logic [SwCh-1:0]     model_off_armed;
  logic                model_backlight;
  logic                model_halted;
  logic [31:0]         model_on_left [SwCh];
  logic [31:0]         model_off_left [SwCh];

  res_t                pending_status [$];
  stim_row_t           opening_rows [$];
  stim_row_t           closing_rows [$];
  int unsigned         mismatches;
  int unsigned         sent_count;
  int unsigned         popped_count;

  power_switch_scheduler i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_action           (in_action),
    .in_channel          (in_channel),
    .in_delay            (in_delay),
    .empty               (empty),
    .pop                 (pop),
    .out_switch_mask     (out_switch_mask),
    .out_backlight_on    (out_backlight_on),
    .out_backlight_write (out_backlight_write),
    .out_save_request    (out_save_request),
    .out_halt_request    (out_halt_request),
    .out_halted          (out_halted),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic res_t status(input logic [MaskW-1:0] mask, input logic bl,
                                  input logic blw, input logic save,
                                  input logic hreq, input logic hlt);
    res_t st;
    st.switch_mask     = mask;
    st.backlight_on    = bl;
    st.backlight_write = blw;
    st.save_request    = save;
    st.halt_request    = hreq;
    st.halted          = hlt;
    return st;
  endfunction

  function automatic void issue_command(input logic [ActionW-1:0] act,
                                        input logic [ChannelW-1:0] ch,
                                        input logic [DelayInW-1:0] dly,
                                        inout res_t st);
    if (model_halted || act > ACT_HALT) return;
    if (act == ACT_HALT) begin
      model_halted = 1'b1;
      st.halt_request = 1'b1;
      return;
    end
    if (ch > BacklightCh || !model_present[ch]) return;
    if (ch == BacklightCh) begin
      model_backlight = (act == ACT_ON);
      st.backlight_write = 1'b1;
      return;
    end
    case (act)
      ACT_OFF:       model_switches[ch[SwIdxW-1:0]] = 1'b0;
      ACT_ON:        model_switches[ch[SwIdxW-1:0]] = 1'b1;
      ACT_TOGGLE:    model_switches[ch[SwIdxW-1:0]] = ~model_switches[ch[SwIdxW-1:0]];
      ACT_SAVE:      st.save_request = 1'b1;
      ACT_SCHED_ON: begin
        model_on_armed[ch[SwIdxW-1:0]] = 1'b1;
        model_on_left[ch[SwIdxW-1:0]]  = dly;
      end
      ACT_SCHED_OFF: begin
        model_off_armed[ch[SwIdxW-1:0]] = 1'b1;
        model_off_left[ch[SwIdxW-1:0]]  = dly;
      end
      default: begin
        model_on_armed[ch[SwIdxW-1:0]]  = 1'b0;
        model_off_armed[ch[SwIdxW-1:0]] = 1'b0;
      end
    endcase
  endfunction

  function automatic res_t step_scheduler(input logic [ActionW-1:0] act,
                                          input logic [ChannelW-1:0] ch,
                                          input logic [DelayInW-1:0] dly);
    res_t st;
    res_t scratch;
    st = '0;
    scratch = '0;
    if (act == ACT_TICK) begin
      // on fires before off within one channel
      for (int i = 0; i < SwCh; i++) begin
        if (model_on_armed[i]) begin
          if (model_on_left[i] <= 32'd1) begin
            model_on_armed[i] = 1'b0;
            issue_command(ACT_ON, ChannelW'(i), '0, scratch);
          end else begin
            model_on_left[i] = model_on_left[i] - 32'd1;
          end
        end
        if (model_off_armed[i]) begin
          if (model_off_left[i] <= 32'd1) begin
            model_off_armed[i] = 1'b0;
            issue_command(ACT_OFF, ChannelW'(i), '0, scratch);
          end else begin
            model_off_left[i] = model_off_left[i] - 32'd1;
          end
        end
      end
    end else begin
      issue_command(act, ch, dly, st);
    end
    st.switch_mask  = model_switches;
    st.backlight_on = model_backlight;
    st.halted       = model_halted;
    return st;
  endfunction

  function automatic void check_field(input string name, input logic [MaskW-1:0] want,
                                      input logic [MaskW-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // called at a falling edge; push stays high after the transaction
  task automatic send_item(input logic [ActionW-1:0] act, input logic [ChannelW-1:0] ch,
                           input logic [DelayInW-1:0] dly, input bit fixed,
                           input res_t want);
    int gap;
    res_t predicted;
    gap = ((sent_count / 48) % 4 == 0) ? 0 : int'($urandom_range(0, 16));
    sent_count++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push       <= 1'b1;
    in_action  <= act;
    in_channel <= ch;
    in_delay   <= dly;
    @(posedge clk);
    while (full) @(posedge clk);
    predicted = step_scheduler(act, ch, dly);
    pending_status.insert(pending_status.size(), fixed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic run_rows(input stim_row_t rows[$]);
    foreach (rows[k])
      send_item(rows[k].act, rows[k].ch, rows[k].dly, rows[k].fixed, rows[k].want);
  endtask

  task automatic write_present(input logic [SwCh:0] value);
    push <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_present = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int quota, input bit any_action);
    int counted;
    int r;
    logic [ActionW-1:0]  act;
    logic [ChannelW-1:0] ch;
    logic [DelayInW-1:0] dly;
    counted = 0;
    while (counted < quota) begin
      r = int'($urandom_range(0, 99));
      if (any_action)     act = ActionW'($urandom_range(0, 15));
      else if (r < 30)    act = ACT_TICK;
      else if (r < 45)    act = ACT_SCHED_ON;
      else if (r < 60)    act = ACT_SCHED_OFF;
      else if (r < 70)    act = ACT_ON;
      else if (r < 78)    act = ACT_OFF;
      else if (r < 86)    act = ACT_TOGGLE;
      else if (r < 91)    act = ACT_SAVE;
      else if (r < 96)    act = ACT_SCHED_RESET;
      else                act = ActionW'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      r = int'($urandom_range(0, 99));
      if (r < 85)         ch = ChannelW'($urandom_range(0, SwCh - 1));
      else if (r < 93)    ch = BacklightCh;
      else                ch = ChannelW'($urandom_range(SwCh + 1, 31));
      r = int'($urandom_range(0, 99));
      if (r < 70)         dly = DelayInW'($urandom_range(0, 12));
      else if (r < 85)    dly = DelayInW'($urandom_range(13, 64));
      else                dly = $urandom();
      counted++;
      send_item(act, ch, dly, 1'b0, NoStatus);
    end
  endtask

  // result side
  initial begin
    int gap;
    res_t want;
    pop = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = ((popped_count / 48) % 4 == 2) ? 0 : int'($urandom_range(0, 16));
      popped_count++;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      if (pending_status.size() == 0) begin
        mismatches++;
        $display("%0t: status transaction with none expected, actual %h", $time,
                 {out_switch_mask, out_backlight_on, out_backlight_write,
                  out_save_request, out_halt_request, out_halted});
      end else begin
        want = pending_status.pop_front();
        check_field("switch_mask", want.switch_mask, out_switch_mask);
        check_field("backlight_on", MaskW'(want.backlight_on), MaskW'(out_backlight_on));
        check_field("backlight_write", MaskW'(want.backlight_write),
                    MaskW'(out_backlight_write));
        check_field("save_request", MaskW'(want.save_request), MaskW'(out_save_request));
        check_field("halt_request", MaskW'(want.halt_request), MaskW'(out_halt_request));
        check_field("halted", MaskW'(want.halted), MaskW'(out_halted));
      end
      @(negedge clk);
    end
  end

  initial begin
    #8000000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [SwCh:0] setting;
    logic [SwCh:0] present_settings [8];
    rst_n      = 1'b0;
    push       = 1'b0;
    in_action  = ACT_OFF;
    in_channel = '0;
    in_delay   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    mismatches   = 0;
    sent_count   = 0;
    popped_count = 0;
    model_present   = '1;
    model_switches  = '0;
    model_on_armed  = '0;
    model_off_armed = '0;
    model_backlight = 1'b0;
    model_halted    = 1'b0;
    for (int i = 0; i < SwCh; i++) begin
      model_on_left[i]  = '0;
      model_off_left[i] = '0;
    end
    present_settings = '{17'h1FFFF, 17'h00000, 17'h0FFFF, 17'h10000,
                         17'h15555, 17'h0AAAA, 17'h1FFFF, 17'h1FFFF};

    opening_rows = '{
      '{ACT_TICK,        5'd0,  32'd0,          1'b1,
        status(16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{ACT_ON,          5'd0,  32'd0,          1'b1,
        status(16'h0001, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{ACT_ON,          5'd15, 32'hFFFF_FFFF,  1'b1,
        status(16'h8001, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{ACT_TOGGLE,      5'd15, 32'd0,          1'b1,
        status(16'h0001, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{ACT_OFF,         5'd0,  32'd0,          1'b1,
        status(16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{ACT_SAVE,        5'd3,  32'd0,          1'b1,
        status(16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0)},
      '{ACT_ON,          BacklightCh, 32'd0,    1'b1,
        status(16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0)},
      '{ACT_SAVE,        BacklightCh, 32'd0,    1'b1,
        status(16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0)},
      '{ACT_ON,          BacklightCh, 32'd0,    1'b1,
        status(16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0)},
      '{ACT_SCHED_ON,    BacklightCh, 32'd5,    1'b1,
        status(16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0)},
      '{ACT_TOGGLE,      BacklightCh, 32'd0,    1'b1,
        status(16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0)},
      '{ACT_ON,          5'd17, 32'd0,          1'b1,
        status(16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{ACT_ON,          5'd31, 32'd0,          1'b1,
        status(16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{ACT_UNUSED_LO,   5'd0,  32'd0,          1'b1,
        status(16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{ACT_UNUSED_HI,   5'd31, 32'hFFFF_FFFF,  1'b1,
        status(16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)},
      '{ACT_SCHED_ON,    5'd2,  32'd0,          1'b0, NoStatus},
      '{ACT_SCHED_OFF,   5'd2,  32'd1,          1'b0, NoStatus},
      '{ACT_SCHED_ON,    5'd5,  32'hFFFF_FFFF,  1'b0, NoStatus},
      '{ACT_SCHED_OFF,   5'd7,  32'd3,          1'b0, NoStatus},
      '{ACT_TOGGLE,      5'd7,  32'd0,          1'b0, NoStatus},
      '{ACT_TICK,        5'd0,  32'd0,          1'b0, NoStatus},
      '{ACT_TICK,        5'd0,  32'd0,          1'b0, NoStatus},
      '{ACT_SCHED_RESET, 5'd5,  32'd0,          1'b0, NoStatus},
      '{ACT_TICK,        5'd0,  32'd0,          1'b0, NoStatus}
    };
    // countdowns armed before the halt still expire, but switch nothing
    closing_rows = '{
      '{ACT_SCHED_ON,    5'd3,  32'd1,          1'b0, NoStatus},
      '{ACT_SCHED_OFF,   5'd4,  32'd2,          1'b0, NoStatus},
      '{ACT_HALT,        5'd9,  32'd0,          1'b0, NoStatus},
      '{ACT_HALT,        5'd0,  32'd0,          1'b0, NoStatus},
      '{ACT_ON,          5'd4,  32'd0,          1'b0, NoStatus},
      '{ACT_ON,          BacklightCh, 32'd0,    1'b0, NoStatus},
      '{ACT_SAVE,        5'd2,  32'd0,          1'b0, NoStatus},
      '{ACT_TICK,        5'd0,  32'd0,          1'b0, NoStatus},
      '{ACT_TICK,        5'd0,  32'd0,          1'b0, NoStatus}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_rows(opening_rows);
    for (int k = 0; k < 8; k++) begin
      setting = (k == 6) ? (SwCh + 1)'($urandom()) : present_settings[k];
      write_present(setting);
      run_random(PhaseQuota, 1'b0);
    end
    write_present('1);
    run_rows(closing_rows);
    run_random(60, 1'b1);
    push <= 1'b0;

    while (pending_status.size() != 0) @(posedge clk);
    repeat (2 * SwCh) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/pss_pkg.sv
sv/pss_front.sv
sv/pss_back.sv
sv/pss_result_fifo.sv
sv/power_switch_scheduler.sv
tb/sv/power_switch_scheduler_test.sv
